// ===== rtl/pfl_pkg.sv =====
// Shared types and constants of the page free-list allocator.
package pfl_pkg;

	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned ADDR_BITS  = 32;
	localparam int unsigned KPAGE_BITS = 12;
	localparam int unsigned ADDED_BITS = 13;
	localparam logic [ADDED_BITS-1:0] ADDED_MAX   = '1;
	localparam logic [31:0]           USABLE_KIND = 32'd1;
	// 4 GiB as a 33-bit byte address
	localparam logic [ADDR_BITS:0]    FOUR_GIB    = {1'b1, {ADDR_BITS{1'b0}}};
	localparam logic [ADDR_BITS:0]    PAGE_STEP   = (ADDR_BITS + 1)'(1) << PAGE_SHIFT;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_REGION = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_UNUSED = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_KERNEL_FIRST = 1'b0,
		CFG_KERNEL_LAST  = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_WALK,
		S_RESP
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] free_address;
		logic [63:0] region_base;
		logic [63:0] region_length;
		logic [31:0] region_kind;
	} in_item_t;

	typedef struct packed {
		logic [31:0]           page_address;
		logic                  granted;
		status_t               status;
		logic [ADDED_BITS-1:0] pages_added;
	} out_item_t;

endpackage

// ===== rtl/pfl_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module pfl_ram #(
	parameter int unsigned WIDTH = 13,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/page_free_list_allocator.sv =====
// Page free-list allocator: LIFO list of free pages threaded through a link RAM.
// Free, unused op, empty allocate, unusable region: finished from S_IDLE, result registered.
// Allocate with a page: one link RAM read, finished in S_ALLOC. Region add: S_WALK visits
// the pages one per cycle, the walk bounded by the link RAM write port.
// Throughput: one item at a time; a finished result may wait in the output register.
// Reset: list empty, head page 0, kernel range empty; link RAM is not cleared.
module page_free_list_allocator
	import pfl_pkg::*;
#(
	parameter int unsigned PAGE_NUMBER_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// item channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_idx_t              cfg_index,
	input  logic [KPAGE_BITS-1:0] cfg_data
);

	localparam int unsigned PNB       = PAGE_NUMBER_BITS;
	localparam int unsigned LINK_W    = PNB + 1;
	localparam int unsigned DEPTH     = 1 << PNB;
	// page number of a 33-bit walk address
	localparam int unsigned WPAGE_W   = ADDR_BITS + 1 - PAGE_SHIFT;

	// control state
	state_t                state_q, state_d;
	logic [PNB-1:0]        head_q, head_d;
	logic                  empty_q, empty_d;
	logic [KPAGE_BITS-1:0] kfirst_q, klast_q;
	logic                  out_valid_q;

	// payload registers
	logic [ADDR_BITS:0]    addr_q, addr_d;   // walk address
	logic [ADDR_BITS:0]    limit_q, limit_d; // walk end, exclusive
	logic [ADDED_BITS-1:0] count_q, count_d;
	out_item_t             res_q, out_q;

	// link RAM ports
	logic                  ram_we, ram_re;
	logic [PNB-1:0]        ram_waddr;
	logic [LINK_W-1:0]     ram_wdata, ram_rdata;

	// completion handling
	out_item_t             res;
	logic                  finish, load_out, save_res;
	logic                  slot_free;

	// region set-up
	logic [ADDR_BITS:0]    reg_sum;
	logic                  reg_usable;

	// walk step
	logic [WPAGE_W-1:0]    wpage;
	logic                  in_range, beyond, is_kernel;

	// free
	logic [ADDR_BITS-PAGE_SHIFT-1:0] fpage;
	logic                            fbeyond;

	logic                  in_xfer;

	pfl_ram #(
		.WIDTH(LINK_W),
		.DEPTH(DEPTH)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;

	// region bounds: base below 4 GiB, end saturated at 4 GiB
	assign reg_usable = (in_data.region_kind == USABLE_KIND) &&
		(in_data.region_base[63:ADDR_BITS] == '0);
	assign reg_sum = {1'b0, in_data.region_base[ADDR_BITS-1:0]} +
		{1'b0, in_data.region_length[ADDR_BITS-1:0]};

	// free address to page number
	assign fpage   = in_data.free_address[ADDR_BITS-1:PAGE_SHIFT];
	assign fbeyond = (fpage >> PNB) != '0;

	// walk step decode
	assign wpage     = addr_q[ADDR_BITS:PAGE_SHIFT];
	assign in_range  = addr_q < limit_q;
	assign beyond    = (wpage >> PNB) != '0;
	assign is_kernel = (wpage >= WPAGE_W'(kfirst_q)) && (wpage <= WPAGE_W'(klast_q));

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		empty_d   = empty_q;
		addr_d    = addr_q;
		limit_d   = limit_q;
		count_d   = count_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = fpage[PNB-1:0];
		// a push links the new page to the old head, or ends the list
		ram_wdata = empty_q ? '0 : {1'b1, head_q};
		res       = '0;
		finish    = 1'b0;
		load_out  = 1'b0;
		save_res  = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					unique case (in_data.op)
						OP_ALLOC: begin
							if (empty_q) begin
								res.status = ST_EMPTY;
								finish     = 1'b1;
							end else begin
								ram_re  = 1'b1;
								state_d = S_ALLOC;
							end
						end
						OP_FREE: begin
							if (fbeyond) begin
								res.status = ST_RANGE;
							end else begin
								ram_we  = 1'b1;
								head_d  = fpage[PNB-1:0];
								empty_d = 1'b0;
							end
							finish = 1'b1;
						end
						OP_REGION: begin
							if (reg_usable) begin
								addr_d  = {1'b0, in_data.region_base[ADDR_BITS-1:0]};
								count_d = '0;
								if (in_data.region_length[63:ADDR_BITS] != '0 ||
									reg_sum > FOUR_GIB) begin
									limit_d = FOUR_GIB;
								end else begin
									limit_d = reg_sum;
								end
								state_d = S_WALK;
							end else begin
								finish = 1'b1;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				res.page_address = ADDR_BITS'(head_q) << PAGE_SHIFT;
				res.granted      = 1'b1;
				if (ram_rdata[PNB]) begin
					head_d = ram_rdata[PNB-1:0];
				end else begin
					empty_d = 1'b1;
				end
				finish = 1'b1;
			end
			S_WALK: begin
				if (in_range && !beyond) begin
					if (!is_kernel) begin
						ram_we    = 1'b1;
						ram_waddr = wpage[PNB-1:0];
						head_d    = wpage[PNB-1:0];
						empty_d   = 1'b0;
						if (count_q != ADDED_MAX) begin
							count_d = count_q + 1'b1;
						end
					end
					addr_d = addr_q + PAGE_STEP;
				end else begin
					res.pages_added = count_q;
					finish          = 1'b1;
				end
			end
			S_RESP: begin
				res = res_q;
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// hand the result to the output register, or park it until the slot drains
		if (finish) begin
			if (slot_free) begin
				load_out = 1'b1;
				state_d  = S_IDLE;
			end else begin
				save_res = 1'b1;
				state_d  = S_RESP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			empty_q     <= 1'b1;
			kfirst_q    <= KPAGE_BITS'(1);
			klast_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			empty_q <= empty_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_KERNEL_FIRST: kfirst_q <= cfg_data;
					CFG_KERNEL_LAST:  klast_q  <= cfg_data;
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_q  <= addr_d;
		limit_q <= limit_d;
		count_q <= count_d;
		if (save_res) begin
			res_q <= res;
		end
		if (load_out) begin
			out_q <= res;
		end
	end

endmodule

// ===== rtl/pfl_checker.sv =====
// Port-level checks of the page free-list allocator, bound to the top level.
module pfl_checker
	import pfl_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a grant always reports ok and a page-aligned address
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.granted |->
		out_data.status == ST_OK && out_data.page_address[PAGE_SHIFT-1:0] == '0)
		else $error("grant with bad status or unaligned address");

	// an empty-list answer grants nothing
	a_empty_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |->
		!out_data.granted && out_data.page_address == '0 && out_data.pages_added == '0)
		else $error("empty-list result carries a page");

	// a region count never comes with a grant or an error
	a_added_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pages_added != '0 |->
		!out_data.granted && out_data.status == ST_OK)
		else $error("pages added mixed with other result");

endmodule

bind page_free_list_allocator pfl_checker u_pfl_checker (.*);

// ===== bench/page_free_list_allocator_test.sv =====
// Self-checking bench for the page free-list allocator: directed rows, then random traffic.
module page_free_list_allocator_test;
	import pfl_pkg::*;

	localparam int unsigned PAGE_BITS    = 12;
	localparam int unsigned PAGE_TOTAL   = 1 << PAGE_BITS;
	localparam int unsigned RANDOM_ITEMS = 135;   // per kernel-range setting
	localparam int unsigned SETTINGS_CNT = 6;
	// QUIET_LIMIT lies well above a full region walk and the long hold-off.
	localparam int unsigned QUIET_LIMIT  = 20000;
	localparam int unsigned LONG_HOLD    = 400;
	localparam int unsigned HOLD_AFTER   = 300;   // results seen before the long hold-off
	localparam logic [63:0] GIB4         = 64'(FOUR_GIB);
	localparam logic [63:0] PAGE_BYTES   = 64'(PAGE_STEP);

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = CFG_KERNEL_FIRST;
	logic [KPAGE_BITS-1:0] cfg_data = '0;

	page_free_list_allocator #(.PAGE_NUMBER_BITS(PAGE_BITS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the list and the kernel range.
	// ------------------------------------------------------------------
	logic [KPAGE_BITS-1:0] kern_first    = 12'd1;
	logic [KPAGE_BITS-1:0] kern_last     = 12'd0;
	logic [PAGE_BITS-1:0]  top_page      = '0;
	bit                    list_is_empty = 1'b1;
	// bit PAGE_BITS set: another free page follows, named by the low bits
	logic [PAGE_BITS:0]    next_free [PAGE_TOTAL];

	out_item_t awaited_responses [$];

	int unsigned mismatches    = 0;
	int unsigned results_seen  = 0;
	int unsigned requests_sent = 0;
	int unsigned grants        = 0;
	int unsigned empty_allocs  = 0;
	int unsigned range_frees   = 0;
	int unsigned region_pages  = 0;
	int unsigned config_writes = 0;
	int unsigned burst_left    = 0;
	int unsigned quiet_cycles  = 0;

	typedef struct {
		in_item_t  req;
		bit        fixed;   // expectation typed in rather than predicted
		out_item_t rsp;
	} directed_row_t;

	directed_row_t directed_rows [$];

	function automatic void stack_page(logic [PAGE_BITS-1:0] pg);
		next_free[pg] = list_is_empty ? '0 : {1'b1, top_page};
		top_page      = pg;
		list_is_empty = 1'b0;
	endfunction

	// Works out the response to one request and moves the predicted list on.
	function automatic out_item_t allocator_response(in_item_t req);
		out_item_t   rsp;
		logic [63:0] ceiling;
		logic [63:0] addr;
		logic [63:0] pg;
		rsp = '0;
		case (req.op)
		OP_ALLOC: begin
			if (list_is_empty) begin
				rsp.status = ST_EMPTY;
			end else begin
				rsp.page_address = 32'(top_page) << PAGE_SHIFT;
				rsp.granted      = 1'b1;
				if (next_free[top_page][PAGE_BITS])
					top_page = next_free[top_page][PAGE_BITS-1:0];
				else
					list_is_empty = 1'b1;
			end
		end
		OP_FREE: begin
			pg = 64'(req.free_address) >> PAGE_SHIFT;
			if (pg >= PAGE_TOTAL)
				rsp.status = ST_RANGE;
			else
				stack_page(pg[PAGE_BITS-1:0]);
		end
		OP_REGION: begin
			if (req.region_kind == USABLE_KIND && req.region_base < GIB4) begin
				// end of region, saturated on wrap, then clipped at 4 GiB
				ceiling = req.region_base + req.region_length;
				if (ceiling < req.region_base)
					ceiling = '1;
				if (ceiling > GIB4)
					ceiling = GIB4;
				for (addr = req.region_base; addr < ceiling; addr += PAGE_BYTES) begin
					pg = addr >> PAGE_SHIFT;
					if (pg >= PAGE_TOTAL)
						break;
					if (!(pg >= 64'(kern_first) && pg <= 64'(kern_last))) begin
						stack_page(pg[PAGE_BITS-1:0]);
						if (rsp.pages_added != ADDED_MAX)
							rsp.pages_added = rsp.pages_added + 1'b1;
					end
				end
			end
		end
		default: ;
		endcase
		return rsp;
	endfunction

	function automatic in_item_t request(op_t op, logic [31:0] fa, logic [63:0] base,
			logic [63:0] len, logic [31:0] kind);
		in_item_t req;
		req.op            = op;
		req.free_address  = fa;
		req.region_base   = base;
		req.region_length = len;
		req.region_kind   = kind;
		return req;
	endfunction

	function automatic out_item_t response(logic [31:0] addr, logic grant, status_t st,
			logic [ADDED_BITS-1:0] added);
		out_item_t rsp;
		rsp.page_address = addr;
		rsp.granted      = grant;
		rsp.status       = st;
		rsp.pages_added  = added;
		return rsp;
	endfunction

	task automatic add_row(in_item_t req, bit fixed, out_item_t rsp);
		directed_row_t row;
		row.req   = req;
		row.fixed = fixed;
		row.rsp   = rsp;
		directed_rows.push_back(row);
	endtask

	// Random request: fields an op ignores carry noise so every input bit moves.
	function automatic in_item_t random_request();
		in_item_t              req;
		int unsigned           pick;
		int unsigned           shape;
		logic [KPAGE_BITS-1:0] near_pg;
		req.op            = OP_NONE;
		req.free_address  = $urandom;
		req.region_base   = {$urandom, $urandom};
		req.region_length = {$urandom, $urandom};
		req.region_kind   = $urandom;
		pick = $urandom_range(99);
		if (pick < 40) begin
			req.op = OP_ALLOC;
		end else if (pick < 70) begin
			req.op = OP_FREE;
			// mostly pages within capacity, now and then a stray address
			if ($urandom_range(4) != 0)
				req.free_address[31:24] = '0;
		end else if (pick < 95) begin
			req.op = OP_REGION;
			shape = $urandom_range(19);
			if (shape < 14) begin
				// usual memory-map entry: low memory, up to a few dozen pages
				req.region_kind        = USABLE_KIND;
				req.region_base[63:24] = '0;
				if (shape < 5) begin
					// straddle the kernel range edge
					near_pg = kern_first + 12'($urandom_range(16)) - 12'd8;
					req.region_base[23:12] = near_pg;
				end
				if ($urandom_range(1))
					req.region_base[11:0] = '0;
				req.region_length = (64'($urandom_range(40)) << PAGE_SHIFT)
					+ 64'($urandom_range(1) ? $urandom_range(4095) : 0);
			end else if (shape < 16) begin
				// reserved or odd entry types
				req.region_base[63:24] = '0;
				req.region_length      = 64'($urandom_range(40)) << PAGE_SHIFT;
			end else if (shape < 18) begin
				// base anywhere, mostly far above 4 GiB
				req.region_kind = USABLE_KIND;
			end else if (shape == 18) begin
				// just below 4 GiB: beyond capacity from the first page
				req.region_kind        = USABLE_KIND;
				req.region_base[63:16] = 48'h0000_0000_FFFF;
			end else begin
				// huge length from low memory: walks to the capacity limit
				req.region_kind        = USABLE_KIND;
				req.region_base[63:24] = '0;
			end
		end
		return req;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Bursts of back-to-back transfers with idle gaps between them.
	task automatic pace();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 24);
		if ($urandom_range(4) == 0)
			return;
		gap = $urandom_range(1, 6);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (gap - 1) @(negedge clk);
	endtask

	task automatic offer(in_item_t req, bit fixed, out_item_t fixed_rsp);
		out_item_t rsp;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		rsp = allocator_response(req);
		awaited_responses.push_back(fixed ? fixed_rsp : rsp);
		requests_sent++;
		pace();
	endtask

	// Stop offering and wait until every awaited response has come back.
	task automatic drain_responses();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (awaited_responses.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [KPAGE_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		CFG_KERNEL_FIRST: kern_first = value;
		CFG_KERNEL_LAST:  kern_last  = value;
		default: ;
		endcase
		config_writes++;
	endtask

	// Registers change only with the block idle and nothing outstanding.
	task automatic set_kernel_range(logic [KPAGE_BITS-1:0] first_pg,
			logic [KPAGE_BITS-1:0] last_pg);
		drain_responses();
		write_reg(CFG_KERNEL_FIRST, first_pg);
		write_reg(CFG_KERNEL_LAST, last_pg);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [KPAGE_BITS-1:0] first_pages [SETTINGS_CNT];
		logic [KPAGE_BITS-1:0] last_pages  [SETTINGS_CNT];
		logic [63:0]           all_ones;
		out_item_t             none;

		all_ones = '1;
		none     = '0;
		// all kernel, top page only, bottom page only, a band, none, random
		first_pages = '{12'd0,    12'd4095, 12'd0, 12'd100, 12'd4095, 12'd0};
		last_pages  = '{12'd4095, 12'd4095, 12'd0, 12'd300, 12'd0,    12'd0};

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed rows, with the reset kernel range (no kernel page).
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b1, response('0, 1'b0, ST_EMPTY, '0));
		add_row(request(OP_NONE, '1, all_ones, all_ones, '1), 1'b1,
			response('0, 1'b0, ST_OK, '0));
		add_row(request(OP_FREE, 32'hFFFF_FFFF, '0, '0, '0), 1'b1,
			response('0, 1'b0, ST_RANGE, '0));
		add_row(request(OP_FREE, 32'h00FF_F000, '0, '0, '0), 1'b1,
			response('0, 1'b0, ST_OK, '0));
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b1,
			response(32'h00FF_F000, 1'b1, ST_OK, '0));
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b1, response('0, 1'b0, ST_EMPTY, '0));
		// low address bits are dropped
		add_row(request(OP_FREE, 32'h0000_0ABC, '0, '0, '0), 1'b1,
			response('0, 1'b0, ST_OK, '0));
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b1, response('0, 1'b1, ST_OK, '0));
		// unusable type, base at 4 GiB, empty region
		add_row(request(OP_REGION, '0, '0, 64'h1_0000, 32'd2), 1'b1,
			response('0, 1'b0, ST_OK, '0));
		add_row(request(OP_REGION, '0, GIB4, 64'h1000, USABLE_KIND), 1'b1, none);
		add_row(request(OP_REGION, '0, '0, '0, USABLE_KIND), 1'b1, none);
		add_row(request(OP_REGION, '0, '0, 64'h3000, USABLE_KIND), 1'b1,
			response('0, 1'b0, ST_OK, 13'd3));
		add_row(request(OP_REGION, '0, 64'hFFFF_FFFF_FFFF_F000, all_ones, USABLE_KIND), 1'b1,
			none);
		// end of region wraps: saturates, then the walk stops at capacity
		add_row(request(OP_REGION, '0, 64'h00FF_E000, all_ones, USABLE_KIND), 1'b1,
			response('0, 1'b0, ST_OK, 13'd2));
		// unaligned base
		add_row(request(OP_REGION, '0, 64'h00FF_F800, 64'h1000, USABLE_KIND), 1'b0, none);
		// the same page freed twice goes on the list twice
		add_row(request(OP_FREE, 32'h0000_5000, '0, '0, '0), 1'b1,
			response('0, 1'b0, ST_OK, '0));
		add_row(request(OP_FREE, 32'h0000_5000, '0, '0, '0), 1'b1,
			response('0, 1'b0, ST_OK, '0));
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b1,
			response(32'h0000_5000, 1'b1, ST_OK, '0));
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b1,
			response(32'h0000_5000, 1'b1, ST_OK, '0));
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b0, none);
		// first page already beyond capacity
		add_row(request(OP_REGION, '0, 64'hFFFF_F000, 64'h2000, USABLE_KIND), 1'b1, none);
		add_row(request(OP_REGION, '0, '0, 64'h1_0000, '1), 1'b1, none);
		add_row(request(OP_FREE, 32'h0100_0000, '0, '0, '0), 1'b1,
			response('0, 1'b0, ST_RANGE, '0));
		add_row(request(OP_ALLOC, '0, '0, '0, '0), 1'b0, none);
		// whole capacity in one entry
		add_row(request(OP_REGION, '0, '0, all_ones, USABLE_KIND), 1'b1,
			response('0, 1'b0, ST_OK, 13'd4096));

		foreach (directed_rows[i])
			offer(directed_rows[i].req, directed_rows[i].fixed, directed_rows[i].rsp);

		// Random traffic under each kernel range setting.
		for (int phase = 0; phase < SETTINGS_CNT; phase++) begin
			if (phase == SETTINGS_CNT - 1) begin
				first_pages[phase] = 12'($urandom_range(4095));
				last_pages[phase]  = first_pages[phase] + 12'($urandom_range(64));
			end
			set_kernel_range(first_pages[phase], last_pages[phase]);
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				// once, let the block run dry in the middle of traffic
				if (phase == 1 && n == RANDOM_ITEMS / 2)
					drain_responses();
				offer(random_request(), 1'b0, none);
			end
		end

		drain_responses();
		repeat (8) @(posedge clk);

		$display("Covered %0d requests, %0d register writes over %0d kernel ranges.",
			requests_sent, config_writes, SETTINGS_CNT + 1);
		$display("%0d pages granted, %0d empty allocations, %0d frees out of range, %0d pages added.",
			grants, empty_allocs, range_frees, region_pages);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver side: a stall pattern that changes with sink_cycle[7:6], and one
	// long hold-off so the block backs up and stalls its input.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned hold_left;
		int unsigned sink_cycle;
		bit          long_hold_done;
		hold_left      = 0;
		sink_cycle     = 0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				case (sink_cycle[7:6])
				2'd0:    out_ready <= 1'b1;
				2'd1:    out_ready <= 1'($urandom_range(1));
				2'd2:    out_ready <= ($urandom_range(3) == 0);
				default: out_ready <= sink_cycle[0];
				endcase
			end
			sink_cycle++;
		end
	end

	// Each response transfer is checked against the oldest awaited response.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_responses.size() == 0) begin
				$error("response with no request outstanding: %h", out_data);
				mismatches++;
			end else begin
				want = awaited_responses.pop_front();
				if (out_data.page_address !== want.page_address) begin
					$error("page_address: expected %h, got %h",
						want.page_address, out_data.page_address);
					mismatches++;
				end
				if (out_data.granted !== want.granted) begin
					$error("granted: expected %b, got %b", want.granted, out_data.granted);
					mismatches++;
				end
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					mismatches++;
				end
				if (out_data.pages_added !== want.pages_added) begin
					$error("pages_added: expected %0d, got %0d",
						want.pages_added, out_data.pages_added);
					mismatches++;
				end
				if (want.granted)
					grants++;
				if (want.status == ST_EMPTY)
					empty_allocs++;
				if (want.status == ST_RANGE)
					range_frees++;
				region_pages += want.pages_added;
			end
		end
	end

	// Watchdog: too long without any transfer on any channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("no transfer for %0d cycles, %0d responses outstanding",
				QUIET_LIMIT, awaited_responses.size());
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// ===== files.f =====
rtl/pfl_pkg.sv
rtl/pfl_ram.sv
rtl/page_free_list_allocator.sv
rtl/pfl_checker.sv
bench/page_free_list_allocator_test.sv
